@@ rtl/core/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, status codes and the alphabet lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'd61;
    localparam int         MAX_RES   = 3;
    localparam int         RES_CNT_W = 2;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_END     = 3'd1,
        ST_INVALID = 3'd2,
        ST_BADPAD  = 3'd3,
        ST_TRUNC   = 3'd4
    } b64d_status_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } b64d_in_t;

    typedef struct packed {
        logic [7:0]   out_byte;
        b64d_status_t status;
        logic         end_of_message;
    } b64d_out_t;

    // up to three result words caused by one input word
    typedef struct packed {
        b64d_out_t [MAX_RES-1:0] res;
        logic [RES_CNT_W-1:0]    count;
    } b64d_bundle_t;

    // {valid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            d = c - 8'd65;
            return {1'b1, d[5:0]};
        end
        if (c >= 8'd97 && c <= 8'd122) begin
            d = c - 8'd71;
            return {1'b1, d[5:0]};
        end
        if (c >= 8'd48 && c <= 8'd57) begin
            d = c + 8'd4;
            return {1'b1, d[5:0]};
        end
        if (c == 8'd43) begin
            return {1'b1, 6'd62};
        end
        if (c == 8'd47) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

endpackage

@@ rtl/core/base64_stream_decoder_top.sv @@
// Flow: an accepted word's results are held in the result buffer, then moved into the
// output register. Throughput: one input word per cycle while no results are pending;
// otherwise one result word per cycle while m_ready stays high, set by the
// single output register; a bundle holds the input until its last word is taken.
// Reset: aresetn synchronous, active low; clears held sextets, stop flag and queue.
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 decoder, standard alphabet, one character in, bytes and status out.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::b64d_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::b64d_out_t m_data
);

    b64d_pkg::b64d_bundle_t bundle;
    logic                   accept;

    assign accept = s_valid && s_ready;

    b64d_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_word (s_data),
        .bundle  (bundle)
    );

    b64d_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .bundle  (bundle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.in_last |-> bundle.count != 2'd0)
        else $error("last word produced no result");

    a_no_eom_midstream: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_data.in_last |-> !bundle.res[0].end_of_message
            && !bundle.res[1].end_of_message && !bundle.res[2].end_of_message)
        else $error("end mark before last word");

    a_status_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == b64d_pkg::ST_DATA) || (m_data.out_byte == 8'd0))
        else $error("non-data result carries a byte");
`endif

endmodule

@@ rtl/core/b64d_core.sv @@
// ----------------------------------------------------------------------------
// b64d_core
// Sextet accumulator: holds pending sextets and turns each input word into
// a bundle of up to three result words.
// ----------------------------------------------------------------------------
module b64d_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  b64d_pkg::b64d_in_t    in_word,
    output b64d_pkg::b64d_bundle_t bundle
);

    logic [17:0] held_sextets_reg, held_sextets_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        stopped_reg, stopped_next;

    logic [6:0]  sx;
    logic [23:0] grp;

    assign sx  = b64d_pkg::sextet_of(in_word.in_char);
    assign grp = {held_sextets_reg, sx[5:0]};

    always_comb begin
        held_sextets_next = held_sextets_reg;
        held_count_next   = held_count_reg;
        stopped_next      = stopped_reg;
        bundle            = '0;

        if (!stopped_reg) begin
            if (in_word.in_char == b64d_pkg::PAD_CHAR) begin
                unique case (held_count_reg)
                    2'd2: begin
                        bundle.res[0].out_byte = held_sextets_reg[11:4];
                        bundle.count = 2'd1;
                    end
                    2'd3: begin
                        bundle.res[0].out_byte = held_sextets_reg[17:10];
                        bundle.res[1].out_byte = held_sextets_reg[9:2];
                        bundle.count = 2'd2;
                    end
                    default: begin
                        bundle.res[0].status = b64d_pkg::ST_BADPAD;
                        bundle.count = 2'd1;
                    end
                endcase
                held_sextets_next = '0;
                held_count_next   = '0;
                stopped_next      = 1'b1;
            end else if (!sx[6]) begin
                bundle.res[0].status = b64d_pkg::ST_INVALID;
                bundle.count      = 2'd1;
                held_sextets_next = '0;
                held_count_next   = '0;
                stopped_next      = 1'b1;
            end else if (held_count_reg == 2'd3) begin
                bundle.res[0].out_byte = grp[23:16];
                bundle.res[1].out_byte = grp[15:8];
                bundle.res[2].out_byte = grp[7:0];
                bundle.count      = 2'd3;
                held_sextets_next = '0;
                held_count_next   = '0;
            end else begin
                held_sextets_next = grp[17:0];
                held_count_next   = held_count_reg + 2'd1;
            end
        end

        if (in_word.in_last) begin
            if (!stopped_next && held_count_next != 2'd0) begin
                bundle.res[0].status = b64d_pkg::ST_TRUNC;
                bundle.count = 2'd1;
            end else if (bundle.count == 2'd0) begin
                bundle.res[0].status = b64d_pkg::ST_END;
                bundle.count = 2'd1;
            end
            unique case (bundle.count)
                2'd2:    bundle.res[1].end_of_message = 1'b1;
                2'd3:    bundle.res[2].end_of_message = 1'b1;
                default: bundle.res[0].end_of_message = 1'b1;
            endcase
            held_sextets_next = '0;
            held_count_next   = '0;
            stopped_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_sextets_reg <= '0;
            held_count_reg   <= '0;
            stopped_reg      <= 1'b0;
        end else if (accept) begin
            held_sextets_reg <= held_sextets_next;
            held_count_reg   <= held_count_next;
            stopped_reg      <= stopped_next;
        end
    end

endmodule

@@ rtl/core/b64d_outq.sv @@
// ----------------------------------------------------------------------------
// b64d_outq
// Result buffer: holds one bundle and feeds its words one at a time into
// the output register.
// ----------------------------------------------------------------------------
module b64d_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  b64d_pkg::b64d_bundle_t bundle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output b64d_pkg::b64d_out_t    m_data
);

    b64d_pkg::b64d_out_t [b64d_pkg::MAX_RES-1:0] slot_reg, slot_next;
    logic [b64d_pkg::RES_CNT_W-1:0] rem_reg, rem_next;
    logic                m_valid_reg, m_valid_next;
    b64d_pkg::b64d_out_t m_data_reg;

    logic take;
    logic accept;

    assign take    = (!m_valid_reg || m_ready) && (rem_reg != '0);
    assign s_ready = (rem_reg == '0) || (rem_reg == 2'd1 && take);
    assign accept  = s_valid && s_ready;

    always_comb begin
        slot_next    = slot_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg;
        if (take) begin
            slot_next    = {slot_reg[0], slot_reg[b64d_pkg::MAX_RES-1:1]};
            rem_next     = rem_reg - 2'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            slot_next = bundle.res;
            rem_next  = bundle.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (take) begin
            m_data_reg <= slot_reg[0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base64_stream_decoder_top: directed groups, padding,
// bad characters and truncation, then random encoded messages with flaws and
// noise. Each accepted word is decoded by a bench-side model and the results
// are compared in order with the words leaving the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT = 2000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    b64d_pkg::b64d_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    b64d_pkg::b64d_out_t m_data;

    base64_stream_decoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // decoder model state
    logic [17:0] sx_held;
    logic [1:0]  sx_count;
    logic        dec_halted;

    b64d_pkg::b64d_out_t decoded_q[$];
    int        fail_count;
    int        items_sent;
    int        idle_cycles;
    int        src_idle_pct;
    int        sink_stall_pct;

    initial begin
        aclk = 1'b0;
    end

    always #4 aclk = ~aclk;

    function automatic bit char_to_sextet(input logic [7:0] c, output logic [5:0] v);
        v = '0;
        if (c >= 8'h41 && c <= 8'h5a) v = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7a) v = 6'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2b) v = 6'd62;
        else if (c == 8'h2f) v = 6'd63;
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
        if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
        return (v == 6'd62) ? 8'h2b : 8'h2f;
    endfunction

    function automatic void push_decoded(input logic [7:0] b,
                                         input b64d_pkg::b64d_status_t st);
        b64d_pkg::b64d_out_t r;
        r.out_byte       = b;
        r.status         = st;
        r.end_of_message = 1'b0;
        decoded_q.push_back(r);
    endfunction

    function automatic void decode_step(input b64d_pkg::b64d_in_t w);
        logic [5:0]          sx;
        logic [23:0]         grp;
        b64d_pkg::b64d_out_t tail;
        int                  added;
        added = 0;
        if (!dec_halted) begin
            if (w.in_char == b64d_pkg::PAD_CHAR) begin
                if (sx_count == 2'd2) begin
                    push_decoded(sx_held[11:4], b64d_pkg::ST_DATA);
                    added = 1;
                end else if (sx_count == 2'd3) begin
                    push_decoded(sx_held[17:10], b64d_pkg::ST_DATA);
                    push_decoded(sx_held[9:2], b64d_pkg::ST_DATA);
                    added = 2;
                end else begin
                    push_decoded(8'd0, b64d_pkg::ST_BADPAD);
                    added = 1;
                end
                sx_held    = '0;
                sx_count   = '0;
                dec_halted = 1'b1;
            end else if (!char_to_sextet(w.in_char, sx)) begin
                push_decoded(8'd0, b64d_pkg::ST_INVALID);
                added      = 1;
                sx_held    = '0;
                sx_count   = '0;
                dec_halted = 1'b1;
            end else if (sx_count == 2'd3) begin
                grp = {sx_held, sx};
                push_decoded(grp[23:16], b64d_pkg::ST_DATA);
                push_decoded(grp[15:8], b64d_pkg::ST_DATA);
                push_decoded(grp[7:0], b64d_pkg::ST_DATA);
                added    = 3;
                sx_held  = '0;
                sx_count = '0;
            end else begin
                sx_held  = {sx_held[11:0], sx};
                sx_count = sx_count + 2'd1;
            end
        end
        if (w.in_last) begin
            if (!dec_halted && sx_count != 2'd0) begin
                push_decoded(8'd0, b64d_pkg::ST_TRUNC);
            end else if (added == 0) begin
                push_decoded(8'd0, b64d_pkg::ST_END);
            end
            tail = decoded_q.pop_back();
            tail.end_of_message = 1'b1;
            decoded_q.push_back(tail);
            sx_held    = '0;
            sx_count   = '0;
            dec_halted = 1'b0;
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic [7:0] c, input logic is_last);
        b64d_pkg::b64d_in_t w;
        w.in_char = c;
        w.in_last = is_last;
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        decode_step(w);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], i == s.len() - 1);
        end
    endtask

    // flaw: 0 clean, 1 random character, 2 cut short, 3 early pad, 4 pads dropped
    task automatic send_message(input int nbytes, input int flaw);
        logic [7:0]  msg[$];
        logic [7:0]  ch[$];
        logic [23:0] grp;
        int          rem;
        int          pos;
        for (int i = 0; i < nbytes; i++) msg.push_back(8'($urandom_range(0, 255)));
        while (msg.size() % 3 != 0) msg.push_back(8'd0);
        for (int i = 0; i < nbytes; i += 3) begin
            rem = nbytes - i;
            grp = {msg[i], msg[i+1], msg[i+2]};
            ch.push_back(sextet_char(grp[23:18]));
            ch.push_back(sextet_char(grp[17:12]));
            if (rem > 1) ch.push_back(sextet_char(grp[11:6]));
            else if (flaw != 4) ch.push_back(b64d_pkg::PAD_CHAR);
            if (rem > 2) ch.push_back(sextet_char(grp[5:0]));
            else if (flaw != 4) ch.push_back(b64d_pkg::PAD_CHAR);
        end
        pos = $urandom_range(0, ch.size() - 1);
        case (flaw)
            1: ch[pos] = 8'($urandom_range(0, 255));
            2: while (ch.size() > pos + 1) void'(ch.pop_back());
            3: ch[pos] = b64d_pkg::PAD_CHAR;
            default: ;
        endcase
        for (int i = 0; i < ch.size(); i++) begin
            send_word(ch[i], i == ch.size() - 1);
        end
    endtask

    // hold the sender off until every expected word is back
    task automatic settle();
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic test_full_groups();
        send_text("AZaz09+/");
        settle();
    endtask

    task automatic test_padding();
        send_text("TQ==");
        send_text("TWE=");
        send_text("T=Q");
        send_text("=");
        settle();
    endtask

    task automatic test_bad_chars();
        send_word("A", 1'b0);
        send_word(8'hff, 1'b0);
        send_word("z", 1'b1);
        send_word(8'h00, 1'b1);
        settle();
    endtask

    task automatic test_truncation();
        send_text("TWF");
        send_text("T");
        settle();
    endtask

    task automatic test_random_streams(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int stop_at;
        int nbytes;
        stop_at        = items_sent + n_items;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (items_sent < stop_at) begin
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                 : $urandom_range(1, 9);
            case ($urandom_range(0, 9))
                0: send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                1: send_message(nbytes, $urandom_range(1, 4));
                default: send_message(nbytes, 0);
            endcase
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        b64d_pkg::b64d_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected word: out_byte %0h status %0d end_of_message %0b",
                       m_data.out_byte, m_data.status, m_data.end_of_message);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, m_data.out_byte);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.end_of_message !== want.end_of_message) begin
                    $error("end_of_message: expected %0b, got %0b",
                           want.end_of_message, m_data.end_of_message);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("base64_stream_decoder_top regression: fail");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        sx_held        = '0;
        sx_count       = '0;
        dec_halted     = 1'b0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_full_groups();
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        test_padding();
        test_bad_chars();
        test_truncation();

        test_random_streams(80, 25, 25);
        test_random_streams(60, 0, 0);
        test_random_streams(80, 50, 50);
        settle();
        test_random_streams(60, 0, 0);
        settle();

        if (fail_count == 0) begin
            $display("base64_stream_decoder_top regression: pass");
        end else begin
            $display("base64_stream_decoder_top regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/b64d_pkg.sv
rtl/core/b64d_core.sv
rtl/core/b64d_outq.sv
rtl/core/base64_stream_decoder_top.sv
tb/tb_top.sv
